@@ rtl/core/ffra_pkg.sv @@
package ffra_pkg;

  localparam int unsigned MaxRegionsDef = 16;
  localparam int unsigned AddrBitsDef   = 32;
  localparam logic [31:0] PoolResetDef  = 32'd65536;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FIT   = 2'd1,
    ST_ZERO     = 2'd2,
    ST_LIST_FUL = 2'd3
  } status_t;

  localparam logic CMD_RESERVE = 1'b0;
  localparam logic CMD_FREE    = 1'b1;

endpackage

@@ rtl/core/first_fit_region_allocator.sv @@
// A reserve scans the free list one entry per cycle, then rewrites it one
//   entry per cycle (shift for split or removal).
// A free scans, merges and writes back one entry per cycle.
// Throughput: one item at a time; in_ready is low while an item is in work or its
//   result waits in the output register.
// Reset (synchronous, rst_n low): pool_size 65536, list holds one region covering the pool.
module first_fit_region_allocator #(
  parameter int unsigned MAX_REGIONS = ffra_pkg::MaxRegionsDef,
  parameter int unsigned ADDR_BITS   = ffra_pkg::AddrBitsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_pool_size,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic [31:0] in_request_size,
  input  logic [31:0] in_alignment,
  input  logic [31:0] in_region_offset,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [31:0] out_alloc_offset,
  output logic [31:0] out_alloc_size
);
  import ffra_pkg::*;

  localparam int unsigned IW = $clog2(MAX_REGIONS);
  localparam int unsigned CW = $clog2(MAX_REGIONS + 2);
  localparam int unsigned VW = 34;
  localparam logic [31:0] AMASK = (ADDR_BITS >= 32) ? 32'hFFFF_FFFF
                                  : 32'((64'd1 << ADDR_BITS) - 64'd1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_RSCAN = 7'b0000010,
    S_RSHFT = 7'b0000100,
    S_RDEL  = 7'b0001000,
    S_FSCAN = 7'b0010000,
    S_FCOPY = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [31:0] pool_r;
  logic [31:0] fs_r [MAX_REGIONS];
  logic [31:0] fl_r [MAX_REGIONS];
  logic [31:0] ms_r [MAX_REGIONS];
  logic [31:0] ml_r [MAX_REGIONS];
  logic [CW-1:0] cnt_r, m_r, i_r, k_r;
  logic          placed_r, over_r;
  logic [31:0] size_r, al_r, off_r, end_r;
  logic [31:0] a_r, rem_r;
  logic [1:0]  st_r;
  logic [31:0] oo_r, os_r;

  // Highest set bit of alignment, 0 treated as 1
  logic [31:0] al_in;
  always_comb begin
    al_in = 32'd1;
    for (int b = 0; b < 32; b++) begin
      if (in_alignment[b]) al_in = 32'd1 << b;
    end
  end

  logic [31:0] sz_in, off_in;
  logic [32:0] end_wide;
  assign sz_in    = in_request_size & AMASK;
  assign off_in   = in_region_offset & AMASK;
  assign end_wide = {1'b0, off_in} + {1'b0, sz_in};

  // Scan entry datapath (shared unit)
  logic [IW-1:0] ix;
  logic [31:0]   cs, cl;
  logic [VW-1:0] aw, padw, need;
  logic [31:0]   pad;
  assign ix   = i_r[IW-1:0];
  assign cs   = fs_r[ix];
  assign cl   = fl_r[ix];
  assign aw   = ({2'b0, cs} + {2'b0, al_r} - VW'(1)) & ~({2'b0, al_r} - VW'(1));
  assign padw = aw - {2'b0, cs};
  assign pad  = padw[31:0];
  assign need = padw + {2'b0, size_r};
  logic fits;
  assign fits = (need <= {2'b0, cl});

  // Free merge step: candidate region (start,len)
  logic          take_new;
  logic [31:0]   ts, tl;
  logic [VW-1:0] pe, re;
  logic          scan_done;
  assign scan_done = (i_r >= cnt_r);
  assign take_new  = !placed_r && (scan_done || off_r < cs);
  assign ts = take_new ? off_r : cs;
  assign tl = take_new ? (end_r - off_r) : cl;
  logic [IW-1:0] mlast;
  assign mlast = IW'(m_r - CW'(1));
  assign pe = {2'b0, ms_r[mlast]} + {2'b0, ml_r[mlast]};
  assign re = {2'b0, ts} + {2'b0, tl};

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_status       = st_r;
  assign out_alloc_offset = oo_r;
  assign out_alloc_size   = os_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) begin
        if (sz_in == 32'd0) state_nxt = S_OUT;
        else if (in_cmd == CMD_RESERVE) state_nxt = S_RSCAN;
        else if (end_wide[32] || end_wide[31:0] > pool_r ? off_in >= pool_r
                 : off_in >= end_wide[31:0]) state_nxt = S_OUT;
        else state_nxt = S_FSCAN;
      end
      S_RSCAN: begin
        if (scan_done) state_nxt = S_OUT;
        else if (fits) begin
          if (pad != 0 && need[31:0] != cl) begin
            state_nxt = (cnt_r >= CW'(MAX_REGIONS)) ? S_OUT : S_RSHFT;
          end else if (pad == 0 && need[31:0] == cl) state_nxt = S_RDEL;
          else state_nxt = S_OUT;
        end
      end
      S_RSHFT: if (k_r <= i_r + CW'(1)) state_nxt = S_OUT;
      S_RDEL:  if (k_r + CW'(1) >= cnt_r) state_nxt = S_OUT;
      S_FSCAN: if (scan_done && placed_r) state_nxt = S_FCOPY;
      S_FCOPY: if (over_r || k_r >= CW'(MAX_REGIONS)) state_nxt = S_OUT;
      S_OUT:   if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control and list registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      pool_r   <= PoolResetDef & AMASK;
      cnt_r    <= CW'(1);
      for (int j = 0; j < MAX_REGIONS; j++) begin
        fs_r[j] <= '0;
        fl_r[j] <= (j == 0) ? (PoolResetDef & AMASK) : 32'd0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        pool_r <= cfg_pool_size & AMASK;
        cnt_r  <= ((cfg_pool_size & AMASK) != 32'd0) ? CW'(1) : CW'(0);
        for (int j = 0; j < MAX_REGIONS; j++) begin
          fs_r[j] <= '0;
          fl_r[j] <= (j == 0) ? (cfg_pool_size & AMASK) : 32'd0;
        end
      end
      case (state_r)
        S_IDLE: if (in_valid) begin
          size_r   <= sz_in;
          al_r     <= al_in;
          off_r    <= off_in;
          end_r    <= (end_wide[32] || end_wide[31:0] > pool_r) ? pool_r : end_wide[31:0];
          i_r      <= '0;
          m_r      <= '0;
          k_r      <= '0;
          placed_r <= 1'b0;
          over_r   <= 1'b0;
          oo_r     <= '0;
          os_r     <= '0;
          st_r     <= (sz_in == 32'd0) ? ST_ZERO : ST_OK;
        end
        S_RSCAN: begin
          if (scan_done) st_r <= ST_NO_FIT;
          else if (fits) begin
            a_r   <= aw[31:0];
            rem_r <= cl - need[31:0];
            if (pad != 0 && need[31:0] != cl) begin
              if (cnt_r >= CW'(MAX_REGIONS)) st_r <= ST_LIST_FUL;
              else begin
                k_r <= cnt_r;
                oo_r <= aw[31:0];
                os_r <= size_r;
              end
            end else begin
              oo_r <= aw[31:0];
              os_r <= size_r;
              if (pad != 0) fl_r[ix] <= pad;
              else if (need[31:0] != cl) begin
                fs_r[ix] <= aw[31:0] + size_r;
                fl_r[ix] <= cl - need[31:0];
              end else k_r <= i_r;
            end
          end else i_r <= i_r + CW'(1);
        end
        // Shift entries up one slot per cycle, then write padding and tail
        S_RSHFT: begin
          if (k_r > i_r + CW'(1)) begin
            fs_r[IW'(k_r)] <= fs_r[IW'(k_r - CW'(1))];
            fl_r[IW'(k_r)] <= fl_r[IW'(k_r - CW'(1))];
            k_r <= k_r - CW'(1);
          end else begin
            fl_r[ix] <= a_r - cs;
            fs_r[IW'(i_r + CW'(1))] <= a_r + size_r;
            fl_r[IW'(i_r + CW'(1))] <= rem_r;
            cnt_r <= cnt_r + CW'(1);
          end
        end
        // Shift entries down one slot per cycle to drop the taken one
        S_RDEL: begin
          if (k_r + CW'(1) < cnt_r) begin
            fs_r[IW'(k_r)] <= fs_r[IW'(k_r + CW'(1))];
            fl_r[IW'(k_r)] <= fl_r[IW'(k_r + CW'(1))];
            k_r <= k_r + CW'(1);
          end else begin
            fs_r[IW'(k_r)] <= '0;
            fl_r[IW'(k_r)] <= '0;
            cnt_r <= cnt_r - CW'(1);
          end
        end
        // Merge one candidate region per cycle into the scratch list
        S_FSCAN: if (!(scan_done && placed_r)) begin
          if (take_new) placed_r <= 1'b1;
          else i_r <= i_r + CW'(1);
          if (tl != 32'd0) begin
            if (m_r == '0) begin
              ms_r[0] <= ts;
              ml_r[0] <= tl;
              m_r     <= CW'(1);
            end else if (pe < {2'b0, ts}) begin
              if (m_r >= CW'(MAX_REGIONS)) over_r <= 1'b1;
              else begin
                ms_r[IW'(m_r)] <= ts;
                ml_r[IW'(m_r)] <= tl;
                m_r <= m_r + CW'(1);
              end
            end else if (re > pe) begin
              ml_r[mlast] <= re[31:0] - ms_r[mlast];
            end
          end
        end
        // Copy the merged list back, one entry per cycle
        S_FCOPY: begin
          if (over_r) st_r <= ST_LIST_FUL;
          else if (k_r < CW'(MAX_REGIONS)) begin
            fs_r[IW'(k_r)] <= (k_r < m_r) ? ms_r[IW'(k_r)] : 32'd0;
            fl_r[IW'(k_r)] <= (k_r < m_r) ? ml_r[IW'(k_r)] : 32'd0;
            k_r <= k_r + CW'(1);
            if (k_r == '0) cnt_r <= m_r;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

@@ sim/tb_first_fit_region_allocator.sv @@
`timescale 1ns / 100ps

module tb_first_fit_region_allocator;
  import ffra_pkg::*;

  localparam int unsigned NumRegions = MaxRegionsDef;

  typedef struct packed {
    status_t     st;
    logic [31:0] offset;
    logic [31:0] size;
  } alloc_result_t;

  typedef enum logic [1:0] {
    ROW_ITEM,
    ROW_POOL,
    ROW_SCATTER
  } row_kind_t;

  typedef struct {
    row_kind_t     kind;
    logic          cmd;
    logic [31:0]   size;
    logic [31:0]   align;
    logic [31:0]   offset;
    bit            typed;
    alloc_result_t want;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [31:0] cfg_pool_size;
  logic        in_valid;
  logic        in_ready;
  logic        in_cmd;
  logic [31:0] in_request_size;
  logic [31:0] in_alignment;
  logic [31:0] in_region_offset;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic [31:0] out_alloc_offset;
  logic [31:0] out_alloc_size;

  // Free-list mirror used to predict each result
  longint unsigned pool_bytes;
  longint unsigned hole_start [NumRegions];
  longint unsigned hole_len [NumRegions];
  int unsigned     hole_count;

  alloc_result_t   expected_allocs[$];
  longint unsigned live_off[$];
  longint unsigned live_len[$];
  int              mismatches;
  int              send_gap_pct;
  int              stall_pct;
  int              reserves_ok;
  int              frees_done;
  int              full_hits;

  first_fit_region_allocator DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_pool_size   (cfg_pool_size),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_request_size (in_request_size),
    .in_alignment    (in_alignment),
    .in_region_offset(in_region_offset),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_alloc_offset(out_alloc_offset),
    .out_alloc_size  (out_alloc_size)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Stall the result channel at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Rebuild the free list as one region covering the pool
  function automatic void reset_holes(longint unsigned bytes);
    pool_bytes = bytes;
    for (int i = 0; i < NumRegions; i++) begin
      hole_start[i] = 0;
      hole_len[i]   = 0;
    end
    hole_len[0] = bytes;
    hole_count  = (bytes != 0) ? 1 : 0;
  endfunction

  function automatic alloc_result_t take_region(longint unsigned size, logic [31:0] align);
    alloc_result_t   res;
    longint unsigned al, s, l, a, pad, rem;
    al = 1;
    for (int b = 31; b >= 0; b--) begin
      if (align[b]) begin
        al = 64'd1 << b;
        break;
      end
    end
    res = '{ST_NO_FIT, 32'd0, 32'd0};
    for (int i = 0; i < hole_count; i++) begin
      s   = hole_start[i];
      l   = hole_len[i];
      a   = (s + al - 1) & ~(al - 1);
      pad = a - s;
      if (l < pad || l - pad < size) continue;
      rem = l - pad - size;
      if (pad > 0 && rem > 0) begin
        if (hole_count >= NumRegions) return '{ST_LIST_FUL, 32'd0, 32'd0};
        for (int k = hole_count; k > i + 1; k--) begin
          hole_start[k] = hole_start[k-1];
          hole_len[k]   = hole_len[k-1];
        end
        hole_len[i]     = pad;
        hole_start[i+1] = a + size;
        hole_len[i+1]   = rem;
        hole_count++;
      end else if (pad > 0) begin
        hole_len[i] = pad;
      end else if (rem > 0) begin
        hole_start[i] = a + size;
        hole_len[i]   = rem;
      end else begin
        for (int k = i; k + 1 < hole_count; k++) begin
          hole_start[k] = hole_start[k+1];
          hole_len[k]   = hole_len[k+1];
        end
        hole_count--;
        hole_start[hole_count] = 0;
        hole_len[hole_count]   = 0;
      end
      return '{ST_OK, a[31:0], size[31:0]};
    end
    return res;
  endfunction

  function automatic alloc_result_t return_region(longint unsigned off, longint unsigned size);
    longint unsigned ts [NumRegions+1];
    longint unsigned tl [NumRegions+1];
    longint unsigned ms [NumRegions+1];
    longint unsigned ml [NumRegions+1];
    longint unsigned stop, pe, re;
    int              n, m;
    bit              placed;
    n      = 0;
    m      = 0;
    placed = 0;
    stop   = off + size;
    if (stop > pool_bytes) stop = pool_bytes;
    if (off >= stop) return '{ST_OK, 32'd0, 32'd0};
    // Insert the returned region in offset order
    for (int i = 0; i < hole_count; i++) begin
      if (!placed && off < hole_start[i]) begin
        ts[n] = off;
        tl[n] = stop - off;
        n++;
        placed = 1;
      end
      ts[n] = hole_start[i];
      tl[n] = hole_len[i];
      n++;
    end
    if (!placed) begin
      ts[n] = off;
      tl[n] = stop - off;
      n++;
    end
    // Merge touching and overlapping regions
    for (int i = 0; i < n; i++) begin
      if (tl[i] == 0) continue;
      if (m == 0) begin
        ms[0] = ts[i];
        ml[0] = tl[i];
        m     = 1;
        continue;
      end
      pe = ms[m-1] + ml[m-1];
      if (pe < ts[i]) begin
        ms[m] = ts[i];
        ml[m] = tl[i];
        m++;
        continue;
      end
      re = ts[i] + tl[i];
      if (re > pe) ml[m-1] = re - ms[m-1];
    end
    if (m > NumRegions) return '{ST_LIST_FUL, 32'd0, 32'd0};
    for (int i = 0; i < NumRegions; i++) begin
      hole_start[i] = (i < m) ? ms[i] : 0;
      hole_len[i]   = (i < m) ? ml[i] : 0;
    end
    hole_count = m;
    return '{ST_OK, 32'd0, 32'd0};
  endfunction

  function automatic alloc_result_t predict_alloc(logic cmd, logic [31:0] size,
                                                  logic [31:0] align, logic [31:0] off);
    if (size == 0) return '{ST_ZERO, 32'd0, 32'd0};
    if (cmd == CMD_RESERVE) return take_region(size, align);
    return return_region(off, size);
  endfunction

  function automatic void note_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s mismatch: expected 0x%08h, got 0x%08h", $time, what, want, got);
    end
  endfunction

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    alloc_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_allocs.size() == 0) begin
        note_mismatch("unexpected result", 32'd0, {30'd0, out_status});
      end else begin
        want = expected_allocs.pop_front();
        if (out_status != want.st) note_mismatch("status", {30'd0, want.st}, {30'd0, out_status});
        if (out_alloc_offset != want.offset) note_mismatch("offset", want.offset, out_alloc_offset);
        if (out_alloc_size != want.size) note_mismatch("size", want.size, out_alloc_size);
      end
    end
  end

  // Present one item, hold it until the transfer, then record its prediction
  task automatic send_item(input logic cmd, input logic [31:0] size, input logic [31:0] align,
                           input logic [31:0] off, input bit typed, input alloc_result_t want,
                           output alloc_result_t got);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_gap_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_cmd           <= cmd;
    in_request_size  <= size;
    in_alignment     <= align;
    in_region_offset <= off;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    got = predict_alloc(cmd, size, align, off);
    if (typed && got != want) begin
      note_mismatch("predictor vs table", {30'd0, want.st}, {30'd0, got.st});
    end
    expected_allocs = {expected_allocs, (typed ? want : got)};
    if (got.st == ST_LIST_FUL) full_hits++;
    if (cmd == CMD_RESERVE && got.st == ST_OK) begin
      reserves_ok++;
      live_off = {live_off, longint'(got.offset)};
      live_len = {live_len, longint'(got.size)};
    end
    if (cmd == CMD_FREE && got.st == ST_OK) frees_done++;
  endtask

  // Hold off the sender until every result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_allocs.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_pool(logic [31:0] bytes);
    drain_results();
    cfg_we        <= 1'b1;
    cfg_pool_size <= bytes;
    @(posedge clk);
    cfg_we <= 1'b0;
    reset_holes(bytes);
    live_off.delete();
    live_len.delete();
    @(posedge clk);
  endtask

  task automatic random_item(longint unsigned cap);
    alloc_result_t   got;
    int              r, idx;
    logic [31:0]     size, align, off;
    longint unsigned trim;
    r = $urandom_range(99);
    if (r < 45) begin
      size = $urandom_range(1, 32'(cap));
      case ($urandom_range(3))
        0:       align = 32'd0;
        1:       align = $urandom_range(1, 4095);
        default: align = 32'd1 << $urandom_range(0, 12);
      endcase
      send_item(CMD_RESERVE, size, align, $urandom, 0, '0, got);
    end else if (r < 85 && live_off.size() != 0) begin
      idx  = $urandom_range(live_off.size() - 1);
      trim = ($urandom_range(9) == 0) ? $urandom_range(0, 32'(live_len[idx] - 1)) : 0;
      send_item(CMD_FREE, 32'(live_len[idx] - trim), $urandom, 32'(live_off[idx] + trim),
                0, '0, got);
      live_off.delete(idx);
      live_len.delete(idx);
    end else begin
      size = ($urandom_range(7) == 0) ? 32'd0 : $urandom;
      send_item(1'($urandom_range(1)), size, $urandom, $urandom, 0, '0, got);
    end
  endtask

  stim_row_t directed [$];

  initial begin
    alloc_result_t   got;
    longint unsigned cap;
    logic [31:0]     pools [5];

    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_pool_size    = 32'd0;
    in_valid         = 1'b0;
    in_cmd           = CMD_RESERVE;
    in_request_size  = 32'd0;
    in_alignment     = 32'd0;
    in_region_offset = 32'd0;
    out_ready        = 1'b0;
    mismatches       = 0;
    reserves_ok      = 0;
    frees_done       = 0;
    full_hits        = 0;
    send_gap_pct     = 24;
    stall_pct        = 24;
    reset_holes(PoolResetDef);

    directed = '{
      '{ROW_ITEM, CMD_RESERVE, 32'd0, 32'd1, 32'd0, 1, '{ST_ZERO, 32'd0, 32'd0}},
      '{ROW_ITEM, CMD_FREE, 32'd0, 32'd0, 32'd5, 1, '{ST_ZERO, 32'd0, 32'd0}},
      '{ROW_ITEM, CMD_RESERVE, 32'd65537, 32'd1, 32'd0, 1, '{ST_NO_FIT, 32'd0, 32'd0}},
      '{ROW_ITEM, CMD_RESERVE, 32'd65536, 32'd0, 32'd0, 1, '{ST_OK, 32'd0, 32'd65536}},
      '{ROW_ITEM, CMD_RESERVE, 32'd1, 32'd1, 32'd0, 1, '{ST_NO_FIT, 32'd0, 32'd0}},
      '{ROW_ITEM, CMD_FREE, 32'd65536, 32'd0, 32'd0, 1, '{ST_OK, 32'd0, 32'd0}},
      '{ROW_ITEM, CMD_FREE, 32'd10, 32'd0, 32'd70000, 1, '{ST_OK, 32'd0, 32'd0}},
      '{ROW_ITEM, CMD_RESERVE, 32'd100, 32'd3, 32'd0, 0, '0},
      '{ROW_ITEM, CMD_RESERVE, 32'd10, 32'd256, 32'd0, 0, '0},
      '{ROW_ITEM, CMD_FREE, 32'hFFFFFFFF, 32'd0, 32'hFFFFFFFF, 1, '{ST_OK, 32'd0, 32'd0}},
      '{ROW_ITEM, CMD_RESERVE, 32'hFFFFFFFF, 32'h80000000, 32'd0, 1,
        '{ST_NO_FIT, 32'd0, 32'd0}},
      '{ROW_ITEM, CMD_FREE, 32'd4, 32'd0, 32'd2, 0, '0},
      '{ROW_ITEM, CMD_FREE, 32'hFFFFFFFF, 32'd0, 32'd0, 1, '{ST_OK, 32'd0, 32'd0}},
      '{ROW_ITEM, CMD_RESERVE, 32'd1, 32'h80000000, 32'd0, 1, '{ST_OK, 32'd0, 32'd1}},
      '{ROW_POOL, CMD_RESERVE, 32'd4096, 32'd0, 32'd0, 0, '0},
      '{ROW_ITEM, CMD_RESERVE, 32'd4096, 32'd1, 32'd0, 1, '{ST_OK, 32'd0, 32'd4096}},
      '{ROW_SCATTER, CMD_FREE, 32'd0, 32'd0, 32'd0, 0, '0},
      '{ROW_ITEM, CMD_FREE, 32'd8, 32'd0, 32'd600, 1, '{ST_LIST_FUL, 32'd0, 32'd0}},
      '{ROW_ITEM, CMD_RESERVE, 32'd1, 32'd4, 32'd0, 1, '{ST_LIST_FUL, 32'd0, 32'd0}},
      '{ROW_POOL, CMD_RESERVE, 32'd1, 32'd0, 32'd0, 0, '0},
      '{ROW_ITEM, CMD_RESERVE, 32'd1, 32'd0, 32'd0, 1, '{ST_OK, 32'd0, 32'd1}},
      '{ROW_POOL, CMD_RESERVE, 32'd0, 32'd0, 32'd0, 0, '0},
      '{ROW_ITEM, CMD_RESERVE, 32'd1, 32'd1, 32'd0, 1, '{ST_NO_FIT, 32'd0, 32'd0}},
      '{ROW_ITEM, CMD_FREE, 32'd5, 32'd0, 32'd0, 1, '{ST_OK, 32'd0, 32'd0}},
      '{ROW_POOL, CMD_RESERVE, 32'hFFFFFFFF, 32'd0, 32'd0, 0, '0},
      '{ROW_ITEM, CMD_RESERVE, 32'hFFFFFFFF, 32'd1, 32'd0, 1,
        '{ST_OK, 32'd0, 32'hFFFFFFFF}},
      '{ROW_ITEM, CMD_FREE, 32'd1, 32'd0, 32'hFFFFFFFE, 1, '{ST_OK, 32'd0, 32'd0}}
    };

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table
    foreach (directed[i]) begin
      case (directed[i].kind)
        ROW_POOL: write_pool(directed[i].size);
        ROW_SCATTER: begin
          // Fill the list to capacity with separated small holes
          for (int k = 0; k < NumRegions; k++) begin
            send_item(CMD_FREE, 32'd8, 32'd0, 32'(k * 32 + 1), 0, '0, got);
          end
        end
        default: begin
          send_item(directed[i].cmd, directed[i].size, directed[i].align, directed[i].offset,
                    directed[i].typed, directed[i].want, got);
        end
      endcase
    end

    // Random traffic over several pool sizes, one stretch without idling
    pools = '{32'd65536, 32'd256, 32'd0, 32'hFFFFFFFF, 32'd48};
    pools[2] = $urandom_range(2, 1 << 20);
    foreach (pools[p]) begin
      write_pool(pools[p]);
      send_gap_pct = (p == 1) ? 0 : 24;
      stall_pct    = (p == 1) ? 0 : 24;
      cap = (pools[p] > 24) ? pools[p] / 12 : 2;
      for (int n = 0; n < 320; n++) random_item(cap);
    end
    drain_results();

    $display("Covered %0d successful reserves, %0d frees and %0d list-full results",
             reserves_ok, frees_done, full_hits);
    $display("across directed and random pool sizes, including zero, one-byte and 32-bit pools");
    if (mismatches == 0 && expected_allocs.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
